@@ hdl/bmf_pkg.sv @@
// Package for the 5x5 box mean filter: item structs, register indexes,
// field widths and parameter defaults. Depends on nothing.
package bmf_pkg;

  localparam int WORD_W          = 32;
  localparam int PIX_W           = 24;
  localparam int IMG_W_BITS      = 11;
  localparam int IMG_H_BITS      = 13;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 13;
  localparam int ROW_W           = 13;
  localparam int OUT_ROW_W       = 12;
  localparam int MAX_HEIGHT      = 4096;
  localparam int WIDTH_RESET     = 640;
  localparam int HEIGHT_RESET    = 480;
  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int WINDOW_SIZE_DEF = 5;

  localparam logic [7:0] ALPHA = 8'hFF;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [WORD_W-1:0] pixel_word;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] filtered_word;
    logic              frame_last;
  } out_item_t;

endpackage

@@ hdl/bmf_ram.sv @@
// Generic single-write, single-read RAM with a registered, read-first output.
// Depends on bmf_pkg for its default sizes only.
module bmf_ram #(
  parameter  int DATA_W = bmf_pkg::PIX_W,
  parameter  int DEPTH  = bmf_pkg::MAX_WIDTH_DEF,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  // A read of the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/box_mean_filter_5x5_unit.sv @@
// Top level of the streaming 5x5 box mean filter: line stores, sliding window,
// masked window sums and the divide by the window area.
// Depends on bmf_pkg and bmf_ram.
//
//  Channel | Direction | Handshake                   | Payload
//  --------+-----------+-----------------------------+--------------------------
//  in_     | input     | in_valid / in_ready         | bmf_pkg::in_item_t
//  out_    | output    | out_valid / out_ready       | bmf_pkg::out_item_t
//  cfg_    | input     | cfg_wr_en (no wait)         | cfg_index, cfg_wdata
//
// One item is accepted every clock cycle while in_ready is high; the pipeline
// is the line-store read, the window shift, the window sum and the reciprocal
// divide, one register each. The result for pixel k follows the item
// k + HALF*width + HALF through them; drain ticks push the last results out.
// Reset (rst_n low, synchronous) restores the register defaults, empties the
// pipeline and marks the window as cleared; the line stores are not cleared.
// A stalled output fills the internal stages, and in_ready falls only when all
// of them hold an item.
module box_mean_filter_5x5_unit #(
  parameter int MAX_WIDTH   = bmf_pkg::MAX_WIDTH_DEF,
  parameter int WINDOW_SIZE = bmf_pkg::WINDOW_SIZE_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  bmf_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output bmf_pkg::out_item_t               out_data,
  input  logic                             cfg_wr_en,
  input  logic [bmf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bmf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  // Window geometry. The line stores hold SPAN-1 rows, one bank per row.
  localparam int HALF   = WINDOW_SIZE / 2;
  localparam int SPAN   = 2 * HALF + 1;
  localparam int LINES  = SPAN - 1;
  localparam int LINE_W = $clog2(LINES);
  localparam int AREA   = SPAN * SPAN;

  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int CNT_W    = COL_W + 1;
  localparam int WID_W    = $clog2(MAX_WIDTH + 1);
  localparam int EW_CMP_W = (WID_W > bmf_pkg::IMG_W_BITS) ? WID_W : bmf_pkg::IMG_W_BITS;
  localparam int LAG_W    = $clog2(HALF * MAX_WIDTH + HALF + 1);
  localparam int RCMP_W   = bmf_pkg::ROW_W + 1;

  // Exact division by the area: multiply by the rounded-up reciprocal.
  localparam int SUM_W   = $clog2(255 * AREA + 1);
  localparam int DIV_SH  = SUM_W + $clog2(AREA);
  localparam int RECIP   = ((1 << DIV_SH) + AREA - 1) / AREA;
  localparam int RECIP_W = SUM_W + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;

  localparam int PIX_W = bmf_pkg::PIX_W;
  localparam int ROW_W = bmf_pkg::ROW_W;

  // Configuration registers and their effective values.
  logic [bmf_pkg::IMG_W_BITS-1:0] width_cfg_r;
  logic [bmf_pkg::IMG_H_BITS-1:0] height_cfg_r;
  logic [WID_W-1:0]               eff_w;
  logic [ROW_W-1:0]               eff_h;
  logic [LAG_W-1:0]               lag;
  logic                           cfg_hit;

  // Stream position counters, advanced as each item is processed.
  logic [COL_W-1:0]              in_column_r, in_column_nxt;
  logic [ROW_W-1:0]              in_row_r, in_row_nxt;
  logic [COL_W-1:0]              out_column_r, out_column_nxt;
  logic [bmf_pkg::OUT_ROW_W-1:0] out_row_r, out_row_nxt;
  logic [LAG_W-1:0]              pos_cnt_r, pos_cnt_nxt;

  // Decisions on the item at the input.
  logic             in_frame;
  logic             proc;
  logic             emit;
  logic             last;
  logic [PIX_W-1:0] newest;
  logic [SPAN-1:0]  rmask, cmask;
  logic [LINE_W-1:0] wr_bank;

  // Pipeline handshake.
  logic out_free, s3_adv, s3_free, s2_adv, s2_free, s1_adv, s1_free;
  logic v1_r, v1_nxt, v2_r, v2_nxt, v3_r, v3_nxt, out_valid_r, out_valid_nxt;

  // Stage 1: line-store read data plus what travels with the item.
  logic [PIX_W-1:0]  ram_rdata [LINES];
  logic [PIX_W-1:0]  s1_col [LINES];
  logic [LINE_W-1:0] s1_sel [LINES];
  logic [PIX_W-1:0]  s1_newest_r;
  logic [LINE_W-1:0] s1_rot_r;
  logic              s1_emit_r, s1_last_r;
  logic [SPAN-1:0]   s1_rmask_r, s1_cmask_r;

  // Stage 2: the sliding window.
  logic [PIX_W-1:0] window_r [SPAN][SPAN];
  logic [PIX_W-1:0] window_nxt [SPAN][SPAN];
  logic             win_clear_r;
  logic             s2_last_r;
  logic [SPAN-1:0]  s2_rmask_r, s2_cmask_r;

  // Stage 3: channel sums.
  logic [SUM_W-1:0] win_sum [3];
  logic [SUM_W-1:0] s3_sum_r [3];
  logic             s3_last_r;

  // Output register.
  bmf_pkg::out_item_t out_data_r, out_data_nxt;

  // ---------------------------------------------------------------------------
  // Effective image size: zero reads as one, too large saturates.
  always_comb begin
    if (width_cfg_r == '0) begin
      eff_w = WID_W'(1);
    end else if (EW_CMP_W'(width_cfg_r) > EW_CMP_W'(MAX_WIDTH)) begin
      eff_w = WID_W'(MAX_WIDTH);
    end else begin
      eff_w = WID_W'(width_cfg_r);
    end
    if (height_cfg_r == '0) begin
      eff_h = ROW_W'(1);
    end else if (height_cfg_r > ROW_W'(bmf_pkg::MAX_HEIGHT)) begin
      eff_h = ROW_W'(bmf_pkg::MAX_HEIGHT);
    end else begin
      eff_h = height_cfg_r;
    end
  end

  // The first result is due once this many items have been taken in.
  assign lag = LAG_W'(eff_w) * LAG_W'(HALF) + LAG_W'(HALF);

  assign cfg_hit = cfg_wr_en &&
                   (cfg_index == bmf_pkg::REG_IMAGE_WIDTH ||
                    cfg_index == bmf_pkg::REG_IMAGE_HEIGHT);

  // ---------------------------------------------------------------------------
  // Handshake. Each stage moves on when the one after it is empty or moving.
  always_comb begin
    out_free = !out_valid_r || out_ready;
    s3_adv   = v3_r && out_free;
    s3_free  = !v3_r || out_free;
    s2_adv   = v2_r && s3_free;
    s2_free  = !v2_r || s3_free;
    s1_adv   = v1_r && s2_free;
    s1_free  = !v1_r || s2_free;
  end

  assign in_ready = s1_free;

  // A drain tick while pixels are still expected is accepted and dropped; once
  // the frame is in, every item flushes and its pixel value is ignored.
  assign in_frame = in_row_r < eff_h;
  assign proc     = in_valid && in_ready &&
                    !(in_frame && in_data.req_type == bmf_pkg::REQ_DRAIN);
  assign newest   = in_frame ? in_data.pixel_word[PIX_W-1:0] : '0;
  assign emit     = pos_cnt_r == lag;
  assign last     = emit &&
                    (ROW_W'(out_row_r) + ROW_W'(1) >= eff_h) &&
                    (CNT_W'(out_column_r) + CNT_W'(1) >= CNT_W'(eff_w));
  assign wr_bank  = in_row_r[LINE_W-1:0];

  // Window positions that fall outside the image count as zero.
  always_comb begin
    logic [CNT_W-1:0]  c;
    logic [RCMP_W-1:0] r;
    for (int k = 0; k < SPAN; k++) begin
      c = CNT_W'(out_column_r) + CNT_W'(k);
      r = RCMP_W'(out_row_r) + RCMP_W'(k);
      cmask[k] = (c >= CNT_W'(HALF)) && (c < CNT_W'(eff_w) + CNT_W'(HALF));
      rmask[k] = (r >= RCMP_W'(HALF)) && (r < RCMP_W'(eff_h) + RCMP_W'(HALF));
    end
  end

  // Position counters. The final result of a frame, or a write to the width or
  // height register, sends everything back to the start of a frame.
  always_comb begin
    in_column_nxt  = in_column_r;
    in_row_nxt     = in_row_r;
    out_column_nxt = out_column_r;
    out_row_nxt    = out_row_r;
    pos_cnt_nxt    = pos_cnt_r;
    if (cfg_hit || (proc && last)) begin
      in_column_nxt  = '0;
      in_row_nxt     = '0;
      out_column_nxt = '0;
      out_row_nxt    = '0;
      pos_cnt_nxt    = '0;
    end else if (proc) begin
      if (emit) begin
        if (CNT_W'(out_column_r) + CNT_W'(1) >= CNT_W'(eff_w)) begin
          out_column_nxt = '0;
          out_row_nxt    = out_row_r + 1'b1;
        end else begin
          out_column_nxt = out_column_r + 1'b1;
        end
      end
      if (CNT_W'(in_column_r) + CNT_W'(1) >= CNT_W'(eff_w)) begin
        in_column_nxt = '0;
        in_row_nxt    = in_row_r + 1'b1;
      end else begin
        in_column_nxt = in_column_r + 1'b1;
      end
      if (!emit) begin
        pos_cnt_nxt = pos_cnt_r + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Line stores: every bank is read at the current column, and the bank of the
  // current row takes the new pixel at the same column in the same cycle.
  for (genvar b = 0; b < LINES; b++) begin : g_line
    bmf_ram #(
      .DATA_W (PIX_W),
      .DEPTH  (MAX_WIDTH)
    ) u_line (
      .clk     (clk),
      .wr_en   (proc && (wr_bank == LINE_W'(b))),
      .wr_addr (in_column_r),
      .wr_data (newest),
      .rd_en   (proc),
      .rd_addr (in_column_r),
      .rd_data (ram_rdata[b])
    );
  end

  // Window row i takes the bank that is i rows on from the row of the item.
  always_comb begin
    for (int i = 0; i < LINES; i++) begin
      s1_sel[i] = s1_rot_r + LINE_W'(i);
      s1_col[i] = ram_rdata[s1_sel[i]];
    end
  end

  // Shift the window one column and load the new column. After the final result
  // of a frame, a reset or a write to the width or height register, the old columns drop out.
  always_comb begin
    for (int i = 0; i < SPAN; i++) begin
      for (int j = 0; j < SPAN - 1; j++) begin
        window_nxt[i][j] = win_clear_r ? '0 : window_r[i][j+1];
      end
    end
    for (int i = 0; i < LINES; i++) begin
      window_nxt[i][SPAN-1] = s1_col[i];
    end
    window_nxt[SPAN-1][SPAN-1] = s1_newest_r;
  end

  // Masked channel sums: rows first, then the row totals.
  always_comb begin
    logic [SUM_W-1:0] row_sum [SPAN][3];
    for (int ch = 0; ch < 3; ch++) begin
      win_sum[ch] = '0;
      for (int i = 0; i < SPAN; i++) begin
        row_sum[i][ch] = '0;
        for (int j = 0; j < SPAN; j++) begin
          if (s2_rmask_r[i] && s2_cmask_r[j]) begin
            row_sum[i][ch] = row_sum[i][ch] + SUM_W'(window_r[i][j][8*ch +: 8]);
          end
        end
      end
      for (int i = 0; i < SPAN; i++) begin
        win_sum[ch] = win_sum[ch] + row_sum[i][ch];
      end
    end
  end

  // Divide by the area and pack: the mean of byte 0 lands in bits 16-23.
  always_comb begin
    logic [PROD_W-1:0] prod [3];
    logic [7:0]        mean [3];
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch] = PROD_W'(s3_sum_r[ch]) * PROD_W'(RECIP);
      mean[ch] = prod[ch][DIV_SH +: 8];
    end
    out_data_nxt.filtered_word = {bmf_pkg::ALPHA, mean[0], mean[1], mean[2]};
    out_data_nxt.frame_last    = s3_last_r;
  end

  // Stage occupancy.
  always_comb begin
    v1_nxt        = proc ? 1'b1 : (s1_adv ? 1'b0 : v1_r);
    v2_nxt        = s1_adv ? s1_emit_r : (s2_adv ? 1'b0 : v2_r);
    v3_nxt        = s2_adv ? 1'b1 : (s3_adv ? 1'b0 : v3_r);
    out_valid_nxt = s3_adv ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  // ---------------------------------------------------------------------------
  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_cfg_r  <= bmf_pkg::IMG_W_BITS'(bmf_pkg::WIDTH_RESET);
      height_cfg_r <= bmf_pkg::IMG_H_BITS'(bmf_pkg::HEIGHT_RESET);
      in_column_r  <= '0;
      in_row_r     <= '0;
      out_column_r <= '0;
      out_row_r    <= '0;
      pos_cnt_r    <= '0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      out_valid_r  <= 1'b0;
      win_clear_r  <= 1'b1;
    end else begin
      if (cfg_wr_en && cfg_index == bmf_pkg::REG_IMAGE_WIDTH) begin
        width_cfg_r <= cfg_wdata[bmf_pkg::IMG_W_BITS-1:0];
      end
      if (cfg_wr_en && cfg_index == bmf_pkg::REG_IMAGE_HEIGHT) begin
        height_cfg_r <= cfg_wdata[bmf_pkg::IMG_H_BITS-1:0];
      end
      in_column_r  <= in_column_nxt;
      in_row_r     <= in_row_nxt;
      out_column_r <= out_column_nxt;
      out_row_r    <= out_row_nxt;
      pos_cnt_r    <= pos_cnt_nxt;
      v1_r         <= v1_nxt;
      v2_r         <= v2_nxt;
      v3_r         <= v3_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_hit) begin
        win_clear_r <= 1'b1;
      end else if (s1_adv) begin
        win_clear_r <= s1_last_r;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (proc) begin
      s1_newest_r <= newest;
      s1_rot_r    <= in_row_r[LINE_W-1:0];
      s1_emit_r   <= emit;
      s1_last_r   <= last;
      s1_rmask_r  <= rmask;
      s1_cmask_r  <= cmask;
    end
    if (s1_adv) begin
      window_r   <= window_nxt;
      s2_last_r  <= s1_last_r;
      s2_rmask_r <= s1_rmask_r;
      s2_cmask_r <= s1_cmask_r;
    end
    if (s2_adv) begin
      s3_sum_r  <= win_sum;
      s3_last_r <= s2_last_r;
    end
    if (s3_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // The input stalls only when every stage holds an item.
  a_stall_full : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (v1_r && v2_r && v3_r && out_valid_r))
    else $error("input stalled with a free pipeline stage");

  // Column counters stay inside the row.
  a_col_range : assert property (@(posedge clk) disable iff (!rst_n)
    (CNT_W'(in_column_r) < CNT_W'(eff_w)) && (CNT_W'(out_column_r) < CNT_W'(eff_w)))
    else $error("column counter beyond the image width");

  // The position counter saturates at the lag.
  a_pos_range : assert property (@(posedge clk) disable iff (!rst_n)
    pos_cnt_r <= lag)
    else $error("position counter passed the lag");

  // The flush never runs more than 2*HALF rows past the frame.
  a_row_range : assert property (@(posedge clk) disable iff (!rst_n)
    RCMP_W'(in_row_r) <= RCMP_W'(eff_h) + RCMP_W'(2 * HALF))
    else $error("input row counter ran past the flush");

  // A summed item moves into a free output register.
  a_sum_to_out : assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && out_free) |=> out_valid_r)
    else $error("summed item lost on its way to the output");

endmodule
